@@ design/utf8d_pkg.sv @@
// Shared types and constants for the lenient UTF-8 decoder.
// Self-contained; used by utf8_lenient_decoder_top.
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] Bits2Mask = 8'h1F;
  localparam logic [7:0] Bits3Mask = 8'h0F;
  localparam logic [7:0] Bits4Mask = 8'h07;
  localparam logic [7:0] PayMask   = 8'h3F;

  localparam logic [LenW-1:0] LenOne = 3'd1;

  typedef enum logic [2:0] {
    ClsAscii,
    ClsCont,
    ClsLead2,
    ClsLead3,
    ClsLead4,
    ClsInvalid
  } byte_class_e;

  typedef struct packed {
    byte_class_e      cls;
    logic [LenW-1:0]  need;
    logic [7:0]       bits;
  } byte_info_t;

  typedef struct packed {
    logic [LenW-1:0] byte_count;
    logic [CpW-1:0]  code_point;
  } result_t;

  function automatic byte_info_t classify(logic [7:0] b);
    byte_info_t info;
    info.need = LenOne;
    info.bits = b;
    if (b[7] == 1'b0) begin
      info.cls = ClsAscii;
    end else if ((b & ContMask) == ContTag) begin
      info.cls = ClsCont;
    end else if ((b & Lead2Mask) == Lead2Tag) begin
      info.cls  = ClsLead2;
      info.need = 3'd2;
      info.bits = b & Bits2Mask;
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      info.cls  = ClsLead3;
      info.need = 3'd3;
      info.bits = b & Bits3Mask;
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      info.cls  = ClsLead4;
      info.need = 3'd4;
      info.bits = b & Bits4Mask;
    end else begin
      info.cls = ClsInvalid;
    end
    return info;
  endfunction

endpackage

@@ design/utf8_lenient_decoder_top.sv @@
// Lenient UTF-8 decoder: byte stream in, code points out.
// Depends on utf8d_pkg for byte classification, constants and the result type.

// Usage:
// The slave channel (s_axis_*) takes one byte of text per beat; tlast marks the
// final byte of a string. The master channel (m_axis_*) gives decoded code
// points with the number of input bytes that formed each one; tlast marks the
// last result caused by one input byte. ASCII bytes and completed sequences
// give one result. A byte inside an open sequence gives none. A broken or
// truncated sequence gives its bytes back raw, one result each, up to four
// results for one input beat. Stray bytes are passed through raw.
// Latency: the results of a byte appear on the master side in the cycle after
// its beat is accepted. Throughput: one input beat per cycle while every byte
// causes at most one result and the receiver keeps tready high; a byte that
// causes more than one result occupies the result buffer until all are taken,
// and the slave side stalls except in the cycle in which the last is taken.
// When the receiver stalls, the held result stays on the port unchanged and the
// input side stops after the buffer's current burst.
// Reset (asynchronous, active low) closes any open sequence and empties the
// result buffer.
module utf8_lenient_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // string_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] byte_count
  output logic        m_axis_tlast_o    // run_last
);

  // Decoder state of the open sequence.
  logic [7:0]  lead_q, lead_d;
  logic [7:0]  cont_q [2];
  logic [2:0]  seq_total_q, seq_total_d;
  logic [1:0]  pending_q, pending_d;
  logic [20:0] accum_q, accum_d;
  logic        cont_we;

  // Result buffer holding the burst of one input beat.
  utf8d_pkg::result_t res_q [utf8d_pkg::MaxResults];
  utf8d_pkg::result_t res_d [utf8d_pkg::MaxResults];
  logic [1:0] head_q, head_d;
  logic [2:0] cnt_q, cnt_d;

  logic in_acc, out_acc;
  logic [7:0] b;
  logic       str_end;
  utf8d_pkg::byte_info_t info;
  logic [20:0] acc_next;
  logic        flush, emit_cur, do_fresh, open_new, append_cont, close_seq;
  logic [20:0] cur_cp;
  logic [2:0]  cur_len;
  logic [2:0]  fcnt;
  logic [2:0]  n_new;
  logic [7:0]  raw_src [3];

  assign b       = s_axis_tdata_i;
  assign str_end = s_axis_tlast_i;
  assign info    = utf8d_pkg::classify(b);
  assign acc_next = {accum_q[14:0], b[5:0]};

  // A new beat is taken when the buffer is empty or its last result leaves now.
  assign s_axis_tready_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready_i);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = res_q[head_q];
  assign m_axis_tlast_o  = (cnt_q == 3'd1);

  // Decide what the current byte does.
  always_comb begin
    flush       = 1'b0;
    emit_cur    = 1'b0;
    do_fresh    = 1'b0;
    open_new    = 1'b0;
    append_cont = 1'b0;
    close_seq   = 1'b0;
    cur_cp      = {13'd0, b};
    cur_len     = utf8d_pkg::LenOne;
    if (seq_total_q != 3'd0) begin
      if (info.cls == utf8d_pkg::ClsCont) begin
        if (({1'b0, pending_q} + 3'd2) >= seq_total_q) begin
          emit_cur  = 1'b1;
          cur_cp    = acc_next;
          cur_len   = seq_total_q;
          close_seq = 1'b1;
        end else if (str_end) begin
          flush    = 1'b1;
          emit_cur = 1'b1;
        end else begin
          append_cont = 1'b1;
        end
      end else begin
        flush    = 1'b1;
        do_fresh = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end
    if (do_fresh) begin
      case (info.cls)
        utf8d_pkg::ClsLead2,
        utf8d_pkg::ClsLead3,
        utf8d_pkg::ClsLead4: begin
          if (str_end) begin
            emit_cur = 1'b1;
          end else begin
            open_new = 1'b1;
          end
        end
        default: emit_cur = 1'b1;
      endcase
    end
  end

  // Assemble the burst: raw bytes of a flushed sequence, then the current result.
  assign raw_src[0] = lead_q;
  assign raw_src[1] = cont_q[0];
  assign raw_src[2] = cont_q[1];
  assign fcnt  = flush ? ({1'b0, pending_q} + 3'd1) : 3'd0;
  assign n_new = fcnt + {2'b00, emit_cur};

  always_comb begin
    for (int k = 0; k < utf8d_pkg::MaxResults; k++) begin
      res_d[k] = res_q[k];
      if (in_acc) begin
        if (k < 3 && 3'(k) < fcnt) begin
          res_d[k].code_point = {13'd0, raw_src[2'(k)]};
          res_d[k].byte_count = utf8d_pkg::LenOne;
        end else begin
          res_d[k].code_point = cur_cp;
          res_d[k].byte_count = cur_len;
        end
      end
    end
  end

  // Next state of the decoder.
  always_comb begin
    lead_d      = lead_q;
    seq_total_d = seq_total_q;
    pending_d   = pending_q;
    accum_d     = accum_q;
    cont_we     = 1'b0;
    if (in_acc) begin
      if (open_new) begin
        lead_d      = b;
        seq_total_d = info.need;
        pending_d   = 2'd0;
        accum_d     = {13'd0, info.bits};
      end else if (append_cont) begin
        cont_we   = 1'b1;
        pending_d = pending_q + 2'd1;
        accum_d   = acc_next;
      end else if (flush || close_seq || str_end) begin
        seq_total_d = 3'd0;
        pending_d   = 2'd0;
      end
    end
  end

  // Buffer bookkeeping.
  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      head_d = 2'd0;
      cnt_d  = n_new;
    end else if (out_acc) begin
      head_d = head_q + 2'd1;
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_total_q <= 3'd0;
      pending_q   <= 2'd0;
      head_q      <= 2'd0;
      cnt_q       <= 3'd0;
    end else begin
      seq_total_q <= seq_total_d;
      pending_q   <= pending_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q  <= lead_d;
    accum_q <= accum_d;
    res_q   <= res_d;
    if (cont_we) begin
      cont_q[pending_q[0]] <= b;
    end
  end

  // The buffer never holds more than one burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result buffer count out of range");

  // A new beat never overwrites results that are still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q != 3'd0 |-> out_acc && cnt_q == 3'd1)
    else $error("input beat overwrote pending results");

  // No continuation bytes are held without an open sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_total_q == 3'd0 |-> pending_q == 2'd0)
    else $error("continuations buffered with no open sequence");

  // The end of a string always closes the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> seq_total_q == 3'd0)
    else $error("sequence left open after string end");

endmodule

@@ tb/sv/tb_utf8_lenient_decoder_top.sv @@
// Self-checking testbench for utf8_lenient_decoder_top.
// It has a directed table and then random UTF-8 streams, checked against its own model or, for typed rows, the table.
// Depends on utf8d_pkg for the byte masks and the packed result layout.
module tb_utf8_lenient_decoder_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 105;
  localparam int unsigned CalmAfter  = 80;   // Random bytes after which idling stops.
  localparam int unsigned SettleCyc  = 20;
  localparam int unsigned DirRows    = 25;

  typedef logic [utf8d_pkg::CpW-1:0]  cp_t;
  typedef logic [utf8d_pkg::LenW-1:0] len_t;

  // One expected code point, as it should leave the master side.
  typedef struct packed {
    cp_t  cp;
    len_t cnt;
    logic last;
  } glyph_t;

  // One row of the directed table. When typed is set, the row must give exactly
  // one result: typed_cp with a byte count of one.
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    cp_t        typed_cp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // Model of the decoder state.
  logic [7:0] seq_lead;
  logic [7:0] seq_cont [2];
  logic [2:0] seq_len;
  logic [1:0] seq_held;
  cp_t        seq_bits;

  // Results of the byte that was just decoded, and the queue of code points still owed.
  glyph_t   burst [utf8d_pkg::MaxResults];
  int       burst_n;
  glyph_t   glyph_q [$];

  dir_row_t dir_rows [DirRows];
  bit       idle_on = 1'b0;
  int       stall_left = 0;
  int       err_cnt = 0;
  int       bytes_sent = 0;
  int       glyphs_seen = 0;
  int       cycle_cnt = 0;

  utf8_lenient_decoder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),    // [7:0] in_byte
    .s_axis_tlast_i  (s_axis_tlast),    // string_end
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [20:0] code_point, [23:21] byte_count
    .m_axis_tlast_o  (m_axis_tlast_o)   // run_last
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function void put_glyph(cp_t cp, len_t cnt);
    if (burst_n < utf8d_pkg::MaxResults) begin
      burst[burst_n] = '{cp: cp, cnt: cnt, last: 1'b0};
      burst_n++;
    end
  endfunction

  function void seq_close();
    seq_lead = 8'h00;
    seq_cont[0] = 8'h00;
    seq_cont[1] = 8'h00;
    seq_len = 3'd0;
    seq_held = 2'd0;
    seq_bits = '0;
  endfunction

  // A broken sequence gives back its lead byte and each continuation it had gathered,
  // one raw result per byte.
  function void seq_spill();
    put_glyph(cp_t'(seq_lead), utf8d_pkg::LenOne);
    for (int i = 0; i < int'(seq_held) && i < 2; i++) begin
      put_glyph(cp_t'(seq_cont[i]), utf8d_pkg::LenOne);
    end
    seq_close();
  endfunction

  // Handles a byte as if no sequence were open.
  function void start_byte(logic [7:0] b, logic e);
    logic [2:0]  need;
    logic [7:0]  payload;
    if (b[7] == 1'b0) begin
      put_glyph(cp_t'(b), utf8d_pkg::LenOne);
      return;
    end
    if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
      need = 3'd2;
      payload = b & utf8d_pkg::Bits2Mask;
    end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
      need = 3'd3;
      payload = b & utf8d_pkg::Bits3Mask;
    end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
      need = 3'd4;
      payload = b & utf8d_pkg::Bits4Mask;
    end else begin
      // A stray continuation byte, or a byte from 0xF8 up.
      put_glyph(cp_t'(b), utf8d_pkg::LenOne);
      return;
    end
    // A lead byte that ends the string cannot open a sequence, so it is passed on raw.
    if (e) begin
      put_glyph(cp_t'(b), utf8d_pkg::LenOne);
      return;
    end
    seq_lead = b;
    seq_len = need;
    seq_held = 2'd0;
    seq_bits = cp_t'(payload);
  endfunction

  // Decodes one accepted byte and leaves its results in burst[0 .. burst_n-1].
  function void decode_byte(logic [7:0] b, logic e);
    cp_t grown;
    burst_n = 0;
    if (seq_len != 3'd0) begin
      if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
        grown = {seq_bits[utf8d_pkg::CpW-7:0], 6'(b & utf8d_pkg::PayMask)};
        if (int'(seq_held) + 2 >= int'(seq_len)) begin
          put_glyph(grown, seq_len);
          seq_close();
        end else if (e) begin
          // The string ends inside the sequence: spill it, then this byte.
          seq_spill();
          put_glyph(cp_t'(b), utf8d_pkg::LenOne);
        end else begin
          if (seq_held < 2'd2) seq_cont[seq_held] = b;
          seq_held = seq_held + 2'd1;
          seq_bits = grown;
        end
      end else begin
        seq_spill();
        start_byte(b, e);
      end
    end else begin
      start_byte(b, e);
    end
    if (e) seq_close();
    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one byte and waits for its beat to be accepted. Once the beat is accepted,
  // its expected results go into the queue. tvalid stays high between bytes unless an idle
  // burst is drawn, so bytes can also arrive back to back.
  task automatic drive_byte(logic [7:0] b, logic e, logic typed, cp_t typed_cp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_byte(b, e);
    if (typed) begin
      glyph_q.insert(glyph_q.size(), '{cp: typed_cp, cnt: utf8d_pkg::LenOne, last: 1'b1});
    end else begin
      for (int i = 0; i < burst_n; i++) glyph_q.insert(glyph_q.size(), burst[i]);
    end
    bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  // Builds one random chunk of text and sends it. Most chunks are well formed. The rest are
  // broken or cut-off sequences, stray bytes and plain noise. Each chunk may end its string.
  task automatic send_chunk();
    logic [7:0]  chunk [$];
    int unsigned kind;
    int unsigned len;
    logic        ends;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(2, 4);
    ends = ($urandom_range(0, 7) == 0);
    case (kind)
      0, 1: chunk.insert(chunk.size(), 8'($urandom_range(0, 127)));
      2, 3, 4, 5: begin
        if (kind < 4) len = kind;  // Leans toward 2- and 3-byte sequences.
        chunk.insert(chunk.size(), lead_byte(len));
        repeat (len - 1) chunk.insert(chunk.size(), cont_byte());
      end
      6: begin
        // Broken by a byte that is not a continuation.
        chunk.insert(chunk.size(), lead_byte(len));
        repeat ($urandom_range(0, len - 2)) chunk.insert(chunk.size(), cont_byte());
        if ($urandom_range(0, 2) == 0) begin
          chunk.insert(chunk.size(), 8'($urandom_range(8'hF8, 8'hFF)));
        end else if ($urandom_range(0, 1) == 0) begin
          chunk.insert(chunk.size(), lead_byte($urandom_range(2, 4)));
        end else begin
          chunk.insert(chunk.size(), 8'($urandom_range(0, 127)));
        end
      end
      7: begin
        // Cut off by the end of the string.
        chunk.insert(chunk.size(), lead_byte(len));
        repeat ($urandom_range(0, len - 2)) chunk.insert(chunk.size(), cont_byte());
        ends = 1'b1;
      end
      8: chunk.insert(chunk.size(), cont_byte());
      default: chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
    endcase
    foreach (chunk[i]) begin
      drive_byte(chunk[i], (i == chunk.size() - 1) ? ends : 1'b0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking and the receiver
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_cnt++;
    if (err_cnt <= 20) begin
      $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Each result beat is compared with the oldest expected code point. After the check,
  // tready is set for the next edge. The receiver stalls in random bursts while idling is on.
  always @(posedge clk_i) begin
    utf8d_pkg::result_t got;
    glyph_t             want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = utf8d_pkg::result_t'(m_axis_tdata_o);
      glyphs_seen++;
      if (glyph_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", got.code_point, 0);
      end else begin
        want = glyph_q.pop_front();
        if (got.code_point != want.cp) report_mismatch("code_point", got.code_point, want.cp);
        if (got.byte_count != want.cnt) report_mismatch("byte_count", got.byte_count, want.cnt);
        if (m_axis_tlast_o != want.last) report_mismatch("run_last", m_axis_tlast_o, want.last);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Safety limit, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still owed", cycle_cnt, glyph_q.size());
      $display("utf8_lenient_decoder_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned settle;
    // Directed part. The rows cover the ends of the byte range, stray bytes, sequences of
    // 2, 3 and 4 bytes (the last one yields 0x1FFFFF), a broken 4-byte sequence that gives a
    // burst of four results, a sequence cut off by the end of the string, a lead byte at the
    // end of a string, and a lead byte that breaks another one.
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000},
      '{8'h7F, 1'b0, 1'b1, 21'h00007F},
      '{8'h80, 1'b0, 1'b1, 21'h000080},
      '{8'hBF, 1'b0, 1'b1, 21'h0000BF},
      '{8'hF8, 1'b0, 1'b1, 21'h0000F8},
      '{8'hFF, 1'b1, 1'b1, 21'h0000FF},
      '{8'hC2, 1'b0, 1'b0, 21'h0},
      '{8'hA9, 1'b0, 1'b0, 21'h0},
      '{8'hE2, 1'b0, 1'b0, 21'h0},
      '{8'h82, 1'b0, 1'b0, 21'h0},
      '{8'hAC, 1'b0, 1'b0, 21'h0},
      '{8'hF7, 1'b0, 1'b0, 21'h0},
      '{8'hBF, 1'b0, 1'b0, 21'h0},
      '{8'hBF, 1'b0, 1'b0, 21'h0},
      '{8'hBF, 1'b0, 1'b0, 21'h0},
      '{8'hF0, 1'b0, 1'b0, 21'h0},
      '{8'h90, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b0, 21'h0},
      '{8'h41, 1'b0, 1'b0, 21'h0},
      '{8'hE0, 1'b0, 1'b0, 21'h0},
      '{8'hA0, 1'b1, 1'b0, 21'h0},
      '{8'hDF, 1'b1, 1'b1, 21'h0000DF},
      '{8'hC3, 1'b0, 1'b0, 21'h0},
      '{8'hC4, 1'b0, 1'b0, 21'h0},
      '{8'h8F, 1'b1, 1'b0, 21'h0}
    };
    seq_close();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      drive_byte(dir_rows[i].b, dir_rows[i].e, dir_rows[i].typed, dir_rows[i].typed_cp);
    end

    // Random part. Both sides idle at first. The last stretch runs at full rate.
    while (bytes_sent < DirRows + RandBytes) begin
      if (bytes_sent >= DirRows + CalmAfter) idle_on = 1'b0;
      send_chunk();
    end
    s_axis_tvalid <= 1'b0;

    while (glyph_q.size() != 0) @(posedge clk_i);
    for (settle = 0; settle < SettleCyc; settle++) @(posedge clk_i);

    $display("Sent %0d bytes (%0d directed, the rest random) and checked %0d results.",
             bytes_sent, DirRows, glyphs_seen);
    $display("The bytes included complete, broken and cut-off sequences, stray bytes and ASCII.");
    if (err_cnt == 0 && glyph_q.size() == 0) begin
      $display("utf8_lenient_decoder_top: match");
    end else begin
      $display("utf8_lenient_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
